// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SBF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbf_pkg.sv
// Shared constants, types and state encodings for the S.Bus frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package sbf_pkg;

  localparam int PAYLOAD_BYTES = 23;
  localparam int CHANNEL_COUNT = 16;
  localparam int BYTE_W        = 8;
  localparam int CHAN_W        = 11;
  localparam int IDX_W         = $clog2(CHANNEL_COUNT);
  localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);
  // bit buffer holds up to CHAN_W-1 leftover bits plus one new byte
  localparam int ACC_W         = CHAN_W + BYTE_W - 1;
  localparam int CNT_W         = $clog2(ACC_W + 1);

  localparam logic [BYTE_W-1:0] FOOTER_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;

  localparam logic [IDX_W-1:0]  LAST_CHAN         = IDX_W'(CHANNEL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_PAYLOAD_ADDR = ADDR_W'(PAYLOAD_BYTES - 1);
  localparam logic [CNT_W-1:0]  CHAN_BITS         = CNT_W'(CHAN_W);
  localparam logic [CNT_W-1:0]  BYTE_BITS         = CNT_W'(BYTE_W);

  typedef enum logic [1:0] {
    PH_FOOTER,
    PH_HEADER,
    PH_DATA
  } sync_phase_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_READ,
    U_LOAD,
    U_EMIT
  } unpack_state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

// File: rtl/sbf_in_if.sv
// Input channel: one received serial byte per word.
// Depends on sbf_pkg.
`timescale 1ns / 1ps

interface sbf_in_if;
  logic                      valid;
  logic                      ready;
  logic [sbf_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/sbf_out_if.sv
// Result channel: one decoded proportional channel per word.
// Depends on sbf_pkg.
`timescale 1ns / 1ps

interface sbf_out_if;
  logic                      valid;
  logic                      ready;
  logic [sbf_pkg::IDX_W-1:0]  channel_index;
  logic [sbf_pkg::CHAN_W-1:0] channel_value;
  logic                      last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

// File: rtl/sbf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sbf_unpack.sv
// Channel unpacker: streams payload bytes out of the RAM into a bit buffer
// and peels off 11-bit channels, LSB first, into an output register.
// Depends on sbf_pkg and sbf_out_if.
`timescale 1ns / 1ps

module sbf_unpack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  output sbf_pkg::rd_req_t            rd_req,
  input  logic [sbf_pkg::BYTE_W-1:0]  rd_data,
  sbf_out_if.source                   out_ch
);

  sbf_pkg::unpack_state_t state_r, state_nxt;

  logic [sbf_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [sbf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [sbf_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [sbf_pkg::IDX_W-1:0]  ch_r, ch_nxt;

  logic                       ov_r, ov_nxt;
  logic [sbf_pkg::IDX_W-1:0]  oidx_r, oidx_nxt;
  logic [sbf_pkg::CHAN_W-1:0] oval_r, oval_nxt;
  logic                       olast_r, olast_nxt;

  logic slot_free;
  logic have_chan;
  logic emit;

  assign slot_free = !ov_r || out_ch.ready;
  assign have_chan = (cnt_r >= sbf_pkg::CHAN_BITS);
  assign emit      = (state_r == sbf_pkg::U_EMIT) && have_chan && slot_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbf_pkg::U_IDLE: begin
        if (start) state_nxt = sbf_pkg::U_READ;
      end
      sbf_pkg::U_READ: state_nxt = sbf_pkg::U_LOAD;
      sbf_pkg::U_LOAD: state_nxt = sbf_pkg::U_EMIT;
      sbf_pkg::U_EMIT: begin
        if (!have_chan) begin
          state_nxt = sbf_pkg::U_READ;
        end else if (slot_free && ch_r == sbf_pkg::LAST_CHAN) begin
          state_nxt = sbf_pkg::U_IDLE;
        end
      end
      default: state_nxt = sbf_pkg::U_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    addr_nxt    = addr_r;
    ch_nxt      = ch_r;
    rd_req.en   = 1'b0;
    rd_req.addr = addr_r;
    busy        = 1'b1;
    unique case (state_r)
      sbf_pkg::U_IDLE: begin
        busy = 1'b0;
        if (start) begin
          acc_nxt  = '0;
          cnt_nxt  = '0;
          addr_nxt = '0;
          ch_nxt   = '0;
        end
      end
      sbf_pkg::U_READ: begin
        rd_req.en = 1'b1;
      end
      sbf_pkg::U_LOAD: begin
        // new byte lands just above the bits still held
        acc_nxt  = acc_r | ({{(sbf_pkg::ACC_W - sbf_pkg::BYTE_W){1'b0}}, rd_data} << cnt_r);
        cnt_nxt  = cnt_r + sbf_pkg::BYTE_BITS;
        addr_nxt = addr_r + sbf_pkg::ADDR_W'(1);
      end
      sbf_pkg::U_EMIT: begin
        if (emit) begin
          acc_nxt = acc_r >> sbf_pkg::CHAN_W;
          cnt_nxt = cnt_r - sbf_pkg::CHAN_BITS;
          ch_nxt  = ch_r + sbf_pkg::IDX_W'(1);
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // output register
  always_comb begin
    oidx_nxt  = oidx_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    ov_nxt    = ov_r && !out_ch.ready;
    if (emit) begin
      ov_nxt    = 1'b1;
      oidx_nxt  = ch_r;
      oval_nxt  = acc_r[sbf_pkg::CHAN_W-1:0];
      olast_nxt = (ch_r == sbf_pkg::LAST_CHAN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbf_pkg::U_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    addr_r  <= addr_nxt;
    ch_r    <= ch_nxt;
    oidx_r  <= oidx_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.channel_index = oidx_r;
  assign out_ch.channel_value = oval_r;
  assign out_ch.last_channel  = olast_r;

endmodule

// File: rtl/sbus_frame_decoder.sv
// S.Bus frame decoder.
//
// Input channel in_ch carries one received serial byte per word. The block
// hunts for a footer byte 0x00 followed directly by a header byte 0x0F, then
// stores the next 23 payload bytes in a payload RAM. Any other byte in the
// header slot sends it back to footer hunting.
// While not decoding, one byte is taken per cycle. The 23rd payload byte
// starts the unpacker, which reads payload bytes 0..21 one at a time from
// the RAM (a read state then a load state for each) and emits sixteen words
// on out_ch: channel index, 11-bit value, and last_channel on channel 15.
// in_ch.ready stays low for the drain; the final word may still sit in the
// output register while the next frame's bytes are taken.
// When out_ch.ready is low the output register holds its word and the
// unpacker waits. Synchronous active-low reset returns to footer hunting
// and clears the output valid; the payload RAM is not cleared, since every
// entry of a frame is written before it is read.
// Depends on sbf_pkg, sbf_in_if, sbf_out_if, sbf_ram, sbf_unpack.
`timescale 1ns / 1ps

module sbus_frame_decoder (
  input  logic       clk,
  input  logic       rst_n,
  sbf_in_if.sink     in_ch,
  sbf_out_if.source  out_ch
);

  sbf_pkg::sync_phase_t phase_r, phase_nxt;
  logic [sbf_pkg::ADDR_W-1:0] byte_cnt_r, byte_cnt_nxt;

  logic               accept;
  logic               unpack_busy;
  logic               ram_we;
  logic               start;
  sbf_pkg::rd_req_t   rd_req;
  logic [sbf_pkg::BYTE_W-1:0] rd_data;

  assign in_ch.ready = !unpack_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        sbf_pkg::PH_FOOTER: begin
          phase_nxt = (in_ch.rx_byte == sbf_pkg::FOOTER_BYTE) ? sbf_pkg::PH_HEADER
                                                             : sbf_pkg::PH_FOOTER;
        end
        sbf_pkg::PH_HEADER: begin
          phase_nxt = (in_ch.rx_byte == sbf_pkg::HEADER_BYTE) ? sbf_pkg::PH_DATA
                                                             : sbf_pkg::PH_FOOTER;
        end
        sbf_pkg::PH_DATA: begin
          if (byte_cnt_r == sbf_pkg::LAST_PAYLOAD_ADDR) phase_nxt = sbf_pkg::PH_FOOTER;
        end
        default: begin
          phase_nxt = (in_ch.rx_byte == sbf_pkg::FOOTER_BYTE) ? sbf_pkg::PH_HEADER
                                                             : sbf_pkg::PH_FOOTER;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    ram_we       = 1'b0;
    start        = 1'b0;
    byte_cnt_nxt = byte_cnt_r;
    unique case (phase_r)
      sbf_pkg::PH_DATA: begin
        if (accept) begin
          ram_we = 1'b1;
          if (byte_cnt_r == sbf_pkg::LAST_PAYLOAD_ADDR) begin
            start        = 1'b1;
            byte_cnt_nxt = '0;
          end else begin
            byte_cnt_nxt = byte_cnt_r + sbf_pkg::ADDR_W'(1);
          end
        end
      end
      default: begin
        byte_cnt_nxt = byte_cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sbf_pkg::PH_FOOTER;
      byte_cnt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  sbf_ram #(
    .WIDTH (sbf_pkg::BYTE_W),
    .DEPTH (sbf_pkg::PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_cnt_r),
    .wdata (in_ch.rx_byte),
    .re    (rd_req.en),
    .raddr (rd_req.addr),
    .rdata (rd_data)
  );

  sbf_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (unpack_busy),
    .rd_req  (rd_req),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/sbf_checker.sv
// Port-level checks for the S.Bus frame decoder, bound to the top level.
// Depends on sbf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sbf_pkg::IDX_W-1:0]  out_channel_index,
  input logic [sbf_pkg::CHAN_W-1:0] out_channel_value,
  input logic                       out_last_channel
);

  // last flag must match the final channel number
  `SBF_ASSERT_SAME(a_last_matches_index, out_valid,
    out_last_channel == (out_channel_index == sbf_pkg::LAST_CHAN),
    "last_channel does not match channel 15")

  // input is held off while a frame is still draining
  `SBF_ASSERT_SAME(a_no_input_mid_frame, out_valid && !out_last_channel, !in_ready,
    "input taken while frame still draining")

  // a word right after the last channel can only open the next frame
  `SBF_ASSERT_NEXT(a_new_frame_after_last, out_valid && out_ready && out_last_channel,
    !out_valid || out_channel_index == '0,
    "word after last channel is not channel 0")

  // stalled word holds its value
  `SBF_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
    out_valid && $stable(out_channel_value) && $stable(out_channel_index),
    "stalled output word changed")

endmodule

bind sbus_frame_decoder sbf_checker u_sbf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_channel_index (out_ch.channel_index),
  .out_channel_value (out_ch.channel_value),
  .out_last_channel  (out_ch.last_channel)
);

// File: test/testbench.sv
// Self-checking testbench for sbus_frame_decoder: drives serial bytes, predicts channel words.
// Depends on sbf_pkg, sbf_in_if, sbf_out_if and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
  import sbf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 100;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 64;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [CHAN_W-1:0] value;
    logic              is_last;
  } chan_word_t;

  typedef logic [CHANNEL_COUNT-1:0][CHAN_W-1:0] chan_set_t;

  logic clk = 1'b0;
  logic rst_n;

  sbf_in_if  in_ch ();
  sbf_out_if out_ch ();

  sbus_frame_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // decoder shadow state
  sync_phase_t       frame_phase;
  int unsigned       payload_cnt;
  logic [BYTE_W-1:0] frame_bytes [PAYLOAD_BYTES];
  chan_word_t        exp_chan_q [$];

  int err_cnt       = 0;
  int words_checked = 0;
  int frames_done   = 0;
  int bytes_sent    = 0;
  int live_bytes    = 0;
  int cycle_cnt     = 0;

  // sender burst control
  int burst_left = 0;
  bit no_gaps    = 1'b0;

  // receiver stall control
  bit          hold_req  = 1'b0;
  int          hold_left = 0;
  int          rx_mode   = 0;
  int          mode_left = 0;
  logic [10:0] stall_pat = 11'b10110011101;

  // Returns 1 when the byte is dropped while hunting for a footer.
  function automatic bit track_byte(input logic [BYTE_W-1:0] b);
    chan_word_t        w;
    logic [CHAN_W-1:0] v;
    int unsigned       n;
    bit                ignored;
    ignored = 1'b0;
    case (frame_phase)
      PH_HEADER: begin
        if (b == HEADER_BYTE) frame_phase = PH_DATA;
        else frame_phase = PH_FOOTER;
      end
      PH_DATA: begin
        frame_bytes[payload_cnt] = b;
        payload_cnt++;
        if (payload_cnt == PAYLOAD_BYTES) begin
          payload_cnt = 0;
          frame_phase = PH_FOOTER;
          frames_done++;
          for (int k = 0; k < CHANNEL_COUNT; k++) begin
            for (int j = 0; j < CHAN_W; j++) begin
              n = k * CHAN_W + j;
              v[j] = frame_bytes[n / BYTE_W][n % BYTE_W];
            end
            w.idx     = IDX_W'(k);
            w.value   = v;
            w.is_last = (k == CHANNEL_COUNT - 1);
            exp_chan_q.push_back(w);
          end
        end
      end
      default: begin
        if (b == FOOTER_BYTE) frame_phase = PH_HEADER;
        else ignored = 1'b1;
      end
    endcase
    return ignored;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CHAN_W'($urandom_range(0, 2047));
  endfunction

  function automatic chan_set_t rand_frame();
    chan_set_t ch;
    for (int k = 0; k < CHANNEL_COUNT; k++) ch[k] = rand_chan();
    return ch;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      if (no_gaps) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(8, 30);
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (!track_byte(b)) live_bytes++;
    bytes_sent++;
  endtask

  task automatic send_frame(input chan_set_t ch, input logic [BYTE_W-1:0] flag);
    logic [PAYLOAD_BYTES*BYTE_W-1:0] bits;
    bits = {flag, ch};
    send_byte(FOOTER_BYTE);
    send_byte(HEADER_BYTE);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(bits[i*BYTE_W +: BYTE_W]);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (exp_chan_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // junk before sync, header slot holding a footer, rejected headers
  task automatic test_sync_rejects();
    send_byte(8'hFF);
    send_byte(HEADER_BYTE);
    send_byte(FOOTER_BYTE);
    send_byte(FOOTER_BYTE);
    send_byte(HEADER_BYTE);
    send_byte(FOOTER_BYTE);
    send_byte(8'h80);
  endtask

  task automatic test_extreme_frame();
    chan_set_t ch;
    for (int k = 0; k < CHANNEL_COUNT; k++) ch[k] = (k % 2 == 0) ? '1 : '0;
    send_frame(ch, 8'hA5);
  endtask

  task automatic test_back_to_back_frames();
    no_gaps = 1'b1;
    repeat (3) send_frame(rand_frame(), BYTE_W'($urandom_range(0, 255)));
    no_gaps = 1'b0;
  endtask

  // receiver holds off; second frame backs up against the stalled drain
  task automatic test_output_backpressure();
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    repeat (2) send_frame(rand_frame(), BYTE_W'($urandom_range(0, 255)));
    no_gaps = 1'b0;
  endtask

  task automatic test_pause_until_drained();
    send_frame(rand_frame(), BYTE_W'($urandom_range(0, 255)));
    wait_all_results();
    send_frame(rand_frame(), BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic test_random_stream();
    int r;
    live_bytes = 0;
    while (live_bytes < RANDOM_BYTES) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        repeat ($urandom_range(0, 2)) send_byte(BYTE_W'($urandom_range(1, 255)));
        send_frame(rand_frame(), BYTE_W'($urandom_range(0, 255)));
      end else if (r < 14) begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (r < 16) begin
        send_byte(FOOTER_BYTE);
        if ($urandom_range(0, 1) == 0) send_byte(FOOTER_BYTE);
        else send_byte(BYTE_W'($urandom_range(16, 255)));
      end else if (r < 18) begin
        // truncated frame: the following bytes fill the rest of the payload
        send_byte(FOOTER_BYTE);
        send_byte(HEADER_BYTE);
        repeat ($urandom_range(1, 22)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (r == 18) begin
        wait_all_results();
      end else begin
        repeat ($urandom_range(5, 15)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver: rotating stall modes plus an on-demand long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 0);
        2: begin
          out_ch.ready <= stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[10:1]};
        end
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // compare each accepted word against the oldest prediction
  always @(posedge clk) begin
    chan_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (exp_chan_q.size() == 0) begin
        $error("unexpected word: channel_index %0d channel_value %0d",
               out_ch.channel_index, out_ch.channel_value);
        err_cnt++;
      end else begin
        e = exp_chan_q.pop_front();
        if (out_ch.channel_index !== e.idx) begin
          $error("channel_index: expected %0d, actual %0d", e.idx, out_ch.channel_index);
          err_cnt++;
        end
        if (out_ch.channel_value !== e.value) begin
          $error("channel_value: expected %0d, actual %0d", e.value, out_ch.channel_value);
          err_cnt++;
        end
        if (out_ch.last_channel !== e.is_last) begin
          $error("last_channel: expected %0d, actual %0d", e.is_last, out_ch.last_channel);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int waited;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = '0;
    out_ch.ready   = 1'b0;
    frame_phase    = PH_FOOTER;
    payload_cnt    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sync_rejects();
    test_extreme_frame();
    test_back_to_back_frames();
    test_output_backpressure();
    test_pause_until_drained();
    test_random_stream();

    in_ch.valid <= 1'b0;
    waited = 0;
    while (exp_chan_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (exp_chan_q.size() != 0) begin
      $error("%0d predicted channel words never arrived", exp_chan_q.size());
      err_cnt++;
    end

    $display("Sent %0d bytes (sync noise, rejected headers, truncated and full frames).",
             bytes_sent);
    $display("Decoded %0d frames, checked %0d channel words under output stalls.",
             frames_done, words_checked);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sbus_frame_decoder.f
+incdir+rtl
rtl/sbf_pkg.sv
rtl/sbf_in_if.sv
rtl/sbf_out_if.sv
rtl/sbf_ram.sv
rtl/sbf_unpack.sv
rtl/sbus_frame_decoder.sv
rtl/sbf_checker.sv
test/testbench.sv
